/* hw/rtl/stb_pkg.sv */
// stb_pkg: shared types, codes and the clip helper for the scaled texture blitter
// used by stb_ctrl, stb_dp and the top level; depends on nothing else
package stb_pkg;

  // opcodes carried in s_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_TEXEL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_LINE_PITCH     = 2'd2;
  localparam logic [1:0] REG_TEXTURE_STRIDE = 2'd3;

  localparam int IN_W  = 136;
  localparam int OUT_W = 88;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAIT,
    S_CHECK,
    S_XL,
    S_XR,
    S_YL,
    S_YR,
    S_COMMIT,
    S_AXGO,
    S_AX,
    S_AY,
    S_MUL,
    S_ADDR,
    S_PIXEL,
    S_NEXT,
    S_OUT
  } state_t;

  // which quotient the divider is working on
  typedef enum logic [2:0] {
    DIV_XL,
    DIV_XR,
    DIV_YL,
    DIV_YR,
    DIV_AX,
    DIV_AY
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_t div_sel;
    logic     commit;
    logic     res_empty;
    logic     pixel;
    logic     res_finish;
    logic     mul;
    logic     res_fetch;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic finished;
  } status_t;

  typedef struct packed {
    logic        empty;
    logic [12:0] org;
    logic [12:0] span;
    logic [12:0] cut_lo;
    logic [12:0] cut_hi;
  } axis_t;

  // clip one axis of the destination against [0, lim)
  function automatic axis_t clip_axis(input logic signed [13:0] pos,
                                      input logic [12:0] len,
                                      input logic [13:0] lim);
    logic signed [15:0] p;
    logic signed [15:0] e;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] lims;
    logic signed [15:0] d_span;
    logic signed [15:0] d_lo;
    logic signed [15:0] d_hi;
    axis_t r;
    p    = {{2{pos[13]}}, pos};
    lims = {2'b00, lim};
    e    = p + {3'b000, len};
    lo   = p[15] ? 16'sd0 : p;
    hi   = (e > lims) ? lims : e;
    d_span = hi - lo;
    d_lo   = lo - p;
    d_hi   = e - hi;
    r.empty  = (len == 13'd0) || (hi <= lo);
    r.org    = lo[12:0];
    r.span   = d_span[12:0];
    r.cut_lo = d_lo[12:0];
    r.cut_hi = d_hi[12:0];
    return r;
  endfunction

endpackage

/* hw/rtl/stb_div.sv */
// stb_div: restoring divider, one quotient bit per cycle, 13-bit quotient
// no package use; the caller guarantees the quotient fits in 13 bits
module stb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [25:0] num,
  input  logic [12:0] den,
  output logic        done,
  output logic [12:0] quo
);

  logic [12:0] rem;
  logic [12:0] dsr;
  logic [3:0]  cnt;
  logic        run;
  logic [13:0] sh;
  logic        take;
  logic [13:0] diff;

  // trial subtract of the shifted remainder
  always_comb begin
    sh   = {rem, quo[12]};
    take = (sh >= {1'b0, dsr});
    diff = sh - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= 4'd0;
      done <= 1'b0;
    end else if (go) begin
      run  <= 1'b1;
      cnt  <= 4'd13;
      done <= 1'b0;
    end else if (run) begin
      cnt  <= cnt - 4'd1;
      done <= (cnt == 4'd1);
      run  <= (cnt != 4'd1);
    end else begin
      done <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= num[25:13];
      quo <= num[12:0];
      dsr <= den;
    end else if (run) begin
      rem <= take ? diff[12:0] : sh[12:0];
      quo <= {quo[11:0], take};
    end
  end

endmodule

/* hw/rtl/stb_ctrl.sv */
// stb_ctrl: sequencer of the blitter: handshakes, divide order, result timing
// depends on stb_pkg
module stb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output stb_pkg::cmd_t    cmd,
  input  stb_pkg::status_t stat
);
  import stb_pkg::*;

  state_t state;
  state_t state_next;
  logic   busy;
  logic   busy_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    busy_next  = busy;
    unique case (state)
      S_IDLE, S_WAIT: begin
        if (s_tvalid) begin
          if (s_tuser == OP_START) state_next = S_CHECK;
          else if (state == S_WAIT) state_next = S_PIXEL;
        end
      end
      S_CHECK: begin
        if (stat.empty) begin
          busy_next  = 1'b0;
          state_next = S_OUT;
        end else begin
          state_next = S_XL;
        end
      end
      S_XL:     if (stat.div_done) state_next = S_XR;
      S_XR:     if (stat.div_done) state_next = S_YL;
      S_YL:     if (stat.div_done) state_next = S_YR;
      S_YR:     if (stat.div_done) state_next = S_COMMIT;
      S_COMMIT: state_next = S_AXGO;
      S_AXGO:   state_next = S_AX;
      S_AX:     if (stat.div_done) state_next = S_AY;
      S_AY:     if (stat.div_done) state_next = S_MUL;
      S_MUL:    state_next = S_ADDR;
      S_ADDR: begin
        busy_next  = 1'b1;
        state_next = S_OUT;
      end
      S_PIXEL:  state_next = S_NEXT;
      S_NEXT: begin
        if (stat.finished) begin
          busy_next  = 1'b0;
          state_next = S_OUT;
        end else begin
          state_next = S_AXGO;
        end
      end
      S_OUT:    if (m_tready) state_next = busy ? S_WAIT : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      S_IDLE, S_WAIT: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_CHECK: begin
        cmd.res_empty = stat.empty;
        cmd.div_go    = !stat.empty;
        cmd.div_sel   = DIV_XL;
      end
      S_XL: begin
        cmd.div_go  = stat.div_done;
        cmd.div_sel = DIV_XR;
      end
      S_XR: begin
        cmd.div_go  = stat.div_done;
        cmd.div_sel = DIV_YL;
      end
      S_YL: begin
        cmd.div_go  = stat.div_done;
        cmd.div_sel = DIV_YR;
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_AXGO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_AX;
      end
      S_AX: begin
        cmd.div_go  = stat.div_done;
        cmd.div_sel = DIV_AY;
      end
      S_MUL:    cmd.mul = 1'b1;
      S_ADDR:   cmd.res_fetch = 1'b1;
      S_PIXEL:  cmd.pixel = 1'b1;
      S_NEXT:   cmd.res_finish = stat.finished;
      S_OUT:    m_tvalid = 1'b1;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/stb_dp.sv */
// stb_dp: blitter datapath: config registers, clip state, counters, divider, result
// depends on stb_pkg and stb_div
module stb_dp #(
  parameter int MAX_FRAME_DIM   = 4096,
  parameter int MAX_TEXTURE_DIM = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_addr,
  input  logic [12:0]             cfg_data,
  input  logic [stb_pkg::IN_W-1:0] in_data,
  input  stb_pkg::cmd_t           cmd,
  output stb_pkg::status_t        stat,
  output logic [stb_pkg::OUT_W-1:0] out_data
);
  import stb_pkg::*;

  localparam logic [13:0] FRAME_MAX = 14'(MAX_FRAME_DIM);
  localparam logic [13:0] TEX_MAX   = 14'(MAX_TEXTURE_DIM);

  // configuration
  logic [12:0] frame_width, frame_height, line_pitch, texture_stride;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= 13'd1024;
      frame_height   <= 13'd768;
      line_pitch     <= 13'd1024;
      texture_stride <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        REG_LINE_PITCH:     line_pitch     <= cfg_data;
        REG_TEXTURE_STRIDE: texture_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [13:0] dx, dy;
  logic [12:0] dw, dh, sw, sh;
  logic [11:0] sx, sy;
  logic [31:0] texel;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx    <= in_data[13:0];
      dy    <= in_data[27:14];
      dw    <= in_data[40:28];
      dh    <= in_data[53:41];
      sx    <= in_data[65:54];
      sy    <= in_data[77:66];
      sw    <= in_data[90:78];
      sh    <= in_data[103:91];
      texel <= in_data[135:104];
    end
  end

  // clip against the frame
  logic [13:0] lim_x, lim_y, stride;
  axis_t ax, ay;
  always_comb begin
    lim_x  = ({1'b0, frame_width}  < FRAME_MAX) ? {1'b0, frame_width}  : FRAME_MAX;
    lim_y  = ({1'b0, frame_height} < FRAME_MAX) ? {1'b0, frame_height} : FRAME_MAX;
    stride = ({1'b0, texture_stride} < TEX_MAX) ? {1'b0, texture_stride} : TEX_MAX;
    ax = clip_axis(dx, dw, lim_x);
    ay = clip_axis(dy, dh, lim_y);
  end

  // blit state
  logic [12:0] ox, oy, cw, ch, rw, rh, col, row;
  logic [13:0] rx, ry;
  logic [12:0] tl_x, tr_x, tl_y, tr_y, qx, qy;
  logic        finished;
  logic [28:0] mul_q;

  // divider operand select
  logic [12:0] fa, fb, den;
  div_sel_t    sel;
  logic        div_done;
  logic [12:0] quo;
  always_comb begin
    unique case (cmd.div_sel)
      DIV_XL:  begin fa = ax.cut_lo; fb = sw; den = dw; end
      DIV_XR:  begin fa = ax.cut_hi; fb = sw; den = dw; end
      DIV_YL:  begin fa = ay.cut_lo; fb = sh; den = dh; end
      DIV_YR:  begin fa = ay.cut_hi; fb = sh; den = dh; end
      DIV_AX:  begin fa = col;       fb = rw; den = cw; end
      DIV_AY:  begin fa = row;       fb = rh; den = ch; end
      default: begin fa = '0;        fb = '0; den = '0; end
    endcase
  end

  stb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  ({13'd0, fa} * {13'd0, fb}),
    .den  (den),
    .done (div_done),
    .quo  (quo)
  );

  // quotient store
  always_ff @(posedge clk) begin
    if (cmd.div_go) sel <= cmd.div_sel;
    if (div_done) begin
      unique case (sel)
        DIV_XL:  tl_x <= quo;
        DIV_XR:  tr_x <= quo;
        DIV_YL:  tl_y <= quo;
        DIV_YR:  tr_y <= quo;
        DIV_AX:  qx   <= quo;
        DIV_AY:  qy   <= quo;
        default: ;
      endcase
    end
  end

  // pixel position and walk
  logic [13:0] col_inc;
  logic [13:0] px, py;
  logic [13:0] row_inc;
  logic [14:0] sxf, syf;
  always_comb begin
    col_inc = {1'b0, col} + 14'd1;
    row_inc = {1'b0, row} + 14'd1;
    px      = {1'b0, ox} + {1'b0, col};
    py      = {1'b0, oy} + {1'b0, row};
    sxf     = {1'b0, rx} + {2'b00, qx};
    syf     = {1'b0, ry} + {2'b00, qy};
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ox  <= ax.org;
      oy  <= ay.org;
      cw  <= ax.span;
      ch  <= ay.span;
      rx  <= {2'b00, sx} + {1'b0, tl_x};
      ry  <= {2'b00, sy} + {1'b0, tl_y};
      rw  <= sw - tl_x - tr_x;
      rh  <= sh - tl_y - tr_y;
      col <= '0;
      row <= '0;
    end else if (cmd.pixel) begin
      if (col_inc >= {1'b0, cw}) begin
        col      <= '0;
        row      <= row_inc[12:0];
        finished <= (row_inc >= {1'b0, ch});
      end else begin
        col      <= col_inc[12:0];
        finished <= 1'b0;
      end
    end
    if (cmd.mul) mul_q <= syf * stride;
  end

  // result register
  logic        r_fetch_valid, r_write_valid, r_done;
  logic [23:0] r_fetch_addr, r_write_addr;
  logic [31:0] r_color;
  logic [26:0] wprod;
  always_comb wprod = py * line_pitch;

  always_ff @(posedge clk) begin
    if (cmd.res_empty || cmd.commit) begin
      r_fetch_valid <= 1'b0;
      r_fetch_addr  <= '0;
      r_write_valid <= 1'b0;
      r_write_addr  <= '0;
      r_color       <= '0;
      r_done        <= cmd.res_empty;
    end else if (cmd.pixel) begin
      r_fetch_valid <= 1'b0;
      r_fetch_addr  <= '0;
      r_write_valid <= 1'b1;
      r_write_addr  <= 24'({13'd0, px} + wprod);
      r_color       <= {texel[31:24], texel[7:0], texel[15:8], texel[23:16]};
      r_done        <= 1'b0;
    end else if (cmd.res_finish) begin
      r_done <= 1'b1;
    end else if (cmd.res_fetch) begin
      r_fetch_valid <= 1'b1;
      r_fetch_addr  <= 24'({14'd0, sxf} + mul_q);
    end
  end

  assign out_data = {5'd0, r_done, r_color, r_write_addr, r_write_valid,
                     r_fetch_addr, r_fetch_valid};

  assign stat.empty    = ax.empty || ay.empty;
  assign stat.div_done = div_done;
  assign stat.finished = finished;

endmodule

/* hw/rtl/scaled_texture_blit_top.sv */
// scaled_texture_blit_top: nearest-neighbor scaled blitter, stream in and out
// depends on stb_pkg, stb_ctrl, stb_dp (which holds stb_div)
//
//  channel  | signals                      | carries
//  ---------+------------------------------+---------------------------------
//  s_*      | s_tvalid s_tready s_tdata    | start rectangles or one texel
//           | s_tuser                      | opcode
//  m_*      | m_tvalid m_tready m_tdata    | fetch / write / done result
//  cfg_*    | cfg_we cfg_addr cfg_data     | frame and texture registers
//
// one item at a time: a start runs four clip divides, two address divides and a
// multiply; a texel runs two address divides of 13 steps each on the shared
// divider, then the stride multiply.
// a texel with no blit running is taken and dropped with no result.
// s_tready stays low while a result waits on m_tready; reset is synchronous.
module scaled_texture_blit_top #(
  parameter int MAX_FRAME_DIM   = 4096,
  parameter int MAX_TEXTURE_DIM = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dest_x, dest_y, dest_w, dest_h, src_x, src_y, src_w, src_h, texel
  input  logic [135:0] s_tdata,
  // opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // fetch_valid, fetch_address, write_valid, write_address, write_color,
  // done_res, zero pad
  output logic [87:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [12:0]  cfg_data
);
  import stb_pkg::*;

  cmd_t    cmd;
  status_t stat;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  stb_dp #(
    .MAX_FRAME_DIM   (MAX_FRAME_DIM),
    .MAX_TEXTURE_DIM (MAX_TEXTURE_DIM)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata)
  );

  // no new item while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");

  // a result is shown once
  a_one_shot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("result repeated");

  // a finished blit never asks for another texel
  a_done_no_fetch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[82] && m_tdata[0]))
    else $error("done with fetch");

endmodule

/* sim/tb_scaled_texture_blit_top.sv */
// tb_scaled_texture_blit_top: self-checking bench for the scaled texture blitter
// depends on stb_pkg and scaled_texture_blit_top; a scoreboard class predicts each result
module tb_scaled_texture_blit_top;
  import stb_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 250;
  localparam int MAX_FRAME   = 4096;
  localparam int MAX_TEX     = 4096;

  typedef struct {
    bit        fetch_valid;
    bit [23:0] fetch_address;
    bit        write_valid;
    bit [23:0] write_address;
    bit [31:0] write_color;
    bit        done;
  } blit_res_t;

  // predicts blit results and checks them in order
  class blit_scoreboard;
    blit_res_t pending[$];
    int errors;
    int frame_w, frame_h, pitch, stride;
    bit busy;
    int org_x, org_y, clip_w, clip_h;
    int srx, sry, srw, srh;
    int col, row;

    function new();
      errors = 0;
      frame_w = 1024; frame_h = 768; pitch = 1024; stride = 1024;
      busy = 0;
      org_x = 0; org_y = 0; clip_w = 0; clip_h = 0;
      srx = 0; sry = 0; srw = 0; srh = 0;
      col = 0; row = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        REG_FRAME_WIDTH:    frame_w = val;
        REG_FRAME_HEIGHT:   frame_h = val;
        REG_LINE_PITCH:     pitch = val;
        REG_TEXTURE_STRIDE: stride = val;
        default: ;
      endcase
    endfunction

    // clip one axis, trim the source in proportion to the cut edges
    function bit clip(int pos, int len, int lim, int s0, int slen,
                      output int org, output int span, output int so, output int sl);
      int stop_pos, lo, hi, tl, tr;
      stop_pos = pos + len;
      lo = (pos < 0) ? 0 : pos;
      hi = (stop_pos > lim) ? lim : stop_pos;
      org = 0; span = 0; so = 0; sl = 0;
      if (len == 0 || hi <= lo) return 0;
      tl = int'((longint'(lo - pos) * slen) / len);
      tr = int'((longint'(stop_pos - hi) * slen) / len);
      org = lo; span = hi - lo; so = s0 + tl; sl = slen - tl - tr;
      return 1;
    endfunction

    function bit [23:0] texel_addr();
      longint sx, sy, st;
      sx = srx + (longint'(col) * srw) / clip_w;
      sy = sry + (longint'(row) * srh) / clip_h;
      st = (stride < MAX_TEX) ? stride : MAX_TEX;
      return 24'((sx + sy * st) & 64'hFFFFFF);
    endfunction

    // accepted input item
    function void note_input(logic op, logic [135:0] d);
      blit_res_t r;
      bit okx, oky;
      int ox, cw, sxo, swo, oy, ch, syo, sho;
      int lim_w, lim_h;
      logic [31:0] t;
      r = '{0, 0, 0, 0, 0, 0};
      if (op == OP_START) begin
        lim_w = (frame_w < MAX_FRAME) ? frame_w : MAX_FRAME;
        lim_h = (frame_h < MAX_FRAME) ? frame_h : MAX_FRAME;
        okx = clip(int'($signed(d[13:0])), int'(d[40:28]), lim_w, int'(d[65:54]),
                   int'(d[90:78]), ox, cw, sxo, swo);
        oky = 0;
        if (okx) begin
          org_x = ox; clip_w = cw; srx = sxo; srw = swo;
          oky = clip(int'($signed(d[27:14])), int'(d[53:41]), lim_h, int'(d[77:66]),
                     int'(d[103:91]), oy, ch, syo, sho);
          if (oky) begin
            org_y = oy; clip_h = ch; sry = syo; srh = sho;
          end
        end
        col = 0; row = 0;
        if (!oky) begin
          busy = 0;
          r.done = 1;
        end else begin
          busy = 1;
          r.fetch_valid = 1;
          r.fetch_address = texel_addr();
        end
        pending.push_back(r);
        return;
      end
      // texel with no blit running is dropped
      if (!busy) return;
      t = d[135:104];
      r.write_valid = 1;
      r.write_address = 24'((longint'(org_x + col) + longint'(org_y + row) * pitch)
                            & 64'hFFFFFF);
      r.write_color = {t[31:24], t[7:0], t[15:8], t[23:16]};
      col++;
      if (col >= clip_w) begin
        col = 0;
        row++;
      end
      if (row >= clip_h) begin
        busy = 0;
        row = 0;
        r.done = 1;
      end else begin
        r.fetch_valid = 1;
        r.fetch_address = texel_addr();
      end
      pending.push_back(r);
    endfunction

    // accepted result item
    function void check_result(logic [87:0] d);
      blit_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.fetch_valid) begin
        $display("%0t: fetch_valid expected %0d actual %0d", $realtime, e.fetch_valid, d[0]);
        errors++;
      end
      if (d[24:1] !== e.fetch_address) begin
        $display("%0t: fetch_address expected %h actual %h", $realtime, e.fetch_address,
                 d[24:1]);
        errors++;
      end
      if (d[25] !== e.write_valid) begin
        $display("%0t: write_valid expected %0d actual %0d", $realtime, e.write_valid, d[25]);
        errors++;
      end
      if (d[49:26] !== e.write_address) begin
        $display("%0t: write_address expected %h actual %h", $realtime, e.write_address,
                 d[49:26]);
        errors++;
      end
      if (d[81:50] !== e.write_color) begin
        $display("%0t: write_color expected %h actual %h", $realtime, e.write_color,
                 d[81:50]);
        errors++;
      end
      if (d[82] !== e.done) begin
        $display("%0t: done_res expected %0d actual %0d", $realtime, e.done, d[82]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [87:0]  m_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [12:0]  cfg_data;

  blit_scoreboard sb;
  bit hold_req;
  bit hold_used;
  int burst_left;
  int items_sent;
  int cycles;

  scaled_texture_blit_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off on request
  initial begin : receiver
    int mode_left;
    int mode;
    mode_left = 0;
    mode = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_req = 0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // offer one item, with bursts and gaps between them
  task automatic send_item(logic op, logic [135:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, d);
    items_sent++;
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every result, then for the block to settle
  task automatic drain();
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_frame(int fw, int fh, int lp, int ts);
    write_reg(REG_FRAME_WIDTH, 13'(fw));
    write_reg(REG_FRAME_HEIGHT, 13'(fh));
    write_reg(REG_LINE_PITCH, 13'(lp));
    write_reg(REG_TEXTURE_STRIDE, 13'(ts));
  endtask

  function automatic logic [135:0] pack_start(int dx, int dy, int dw, int dh,
                                              int sx, int sy, int sw, int sh);
    return {32'd0, 13'(sh), 13'(sw), 12'(sy), 12'(sx), 13'(dh), 13'(dw), 14'(dy), 14'(dx)};
  endfunction

  function automatic logic [135:0] texel_item(logic [31:0] t);
    logic [135:0] d;
    d = 136'({$urandom, $urandom, $urandom, $urandom, $urandom});
    d[135:104] = t;
    return d;
  endfunction

  // feed texels while the blit runs, at most cap of them
  task automatic feed_texels(int cap);
    int n;
    n = 0;
    while (sb.busy && n < cap) begin
      send_item(OP_TEXEL, texel_item($urandom));
      n++;
    end
  endtask

  // one edge coordinate and length so that the clipped span stays small
  task automatic pick_axis(int lim, output int pos, output int len);
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      len = $urandom_range(0, 8191);
      pos = ($urandom_range(0, 1)) ? lim - $urandom_range(0, 4) : -(len - $urandom_range(0, 4));
    end else begin
      len = $urandom_range(1, 6);
      case ($urandom_range(0, 2))
        0: pos = -len + $urandom_range(0, len + 3);
        1: pos = lim - $urandom_range(0, len + 3);
        default: pos = $urandom_range(0, (lim > 8) ? lim - 8 : 0);
      endcase
    end
    if (pos > 8191) pos = 8191;
    if (pos < -8192) pos = -8192;
  endtask

  task automatic random_phase(int fw, int fh, int count);
    int lw, lh, dx, dy, dw, dh, sw, sh, r, stop_at;
    lw = (fw < MAX_FRAME) ? fw : MAX_FRAME;
    lh = (fh < MAX_FRAME) ? fh : MAX_FRAME;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        // noise start with fully random fields, then a few texels
        send_item(OP_START, 136'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        feed_texels($urandom_range(0, 4));
      end else if (r == 1) begin
        if (!sb.busy) send_item(OP_TEXEL, texel_item($urandom));
      end else begin
        pick_axis(lw, dx, dw);
        pick_axis(lh, dy, dh);
        sw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 12);
        sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 12);
        send_item(OP_START, pack_start(dx, dy, dw, dh, $urandom_range(0, 4095),
                                       $urandom_range(0, 4095), sw, sh));
        // a few blits are abandoned by the next start
        feed_texels(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 40);
      end
      if (items_sent > 500 && !hold_used) begin
        hold_req = 1;
        hold_used = 1;
      end
    end
  endtask

  // stimulus
  initial begin
    sb = new();
    cycles = 0;
    hold_req = 0;
    hold_used = 0;
    burst_left = 0;
    items_sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_START;
    cfg_we = 1'b0;
    cfg_addr = REG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset frame setting
    send_item(OP_TEXEL, texel_item(32'hFFFFFFFF));
    send_item(OP_START, pack_start(0, 0, 0, 5, 0, 0, 4, 4));
    send_item(OP_START, pack_start(-8192, -8192, 8191, 8191, 4095, 4095, 4096, 4096));
    feed_texels(3);
    send_item(OP_START, pack_start(8191, 8191, 8191, 8191, 0, 0, 4096, 4096));
    send_item(OP_START, pack_start(1022, 766, 4, 3, 100, 200, 0, 0));
    feed_texels(40);
    send_item(OP_START, pack_start(-2, -1, 4, 3, 4095, 4095, 4096, 4096));
    send_item(OP_TEXEL, texel_item(32'h00000000));
    send_item(OP_TEXEL, texel_item(32'h12345678));
    send_item(OP_START, pack_start(1020, 765, 8191, 8191, 7, 9, 8191, 8191));
    feed_texels(40);
    send_item(OP_TEXEL, texel_item(32'hA5C3F00F));
    drain();

    // random phases across frame settings
    set_frame(1024, 768, 1024, 1024);
    random_phase(1024, 768, 160);
    drain();
    set_frame(16, 12, 20, 24);
    random_phase(16, 12, 160);
    drain();
    set_frame(1, 1, 1, 1);
    random_phase(1, 1, 120);
    drain();
    set_frame(4096, 4096, 4096, 4096);
    random_phase(4096, 4096, 160);
    drain();
    set_frame(8191, 8191, 8191, 8191);
    random_phase(8191, 8191, 140);
    drain();
    set_frame(0, 0, 0, 0);
    random_phase(0, 0, 40);
    drain();
    set_frame(37, 5, 0, 0);
    random_phase(37, 5, 160);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* scaled_texture_blit_top.f */
hw/rtl/stb_pkg.sv
hw/rtl/stb_div.sv
hw/rtl/stb_ctrl.sv
hw/rtl/stb_dp.sv
hw/rtl/scaled_texture_blit_top.sv
sim/tb_scaled_texture_blit_top.sv
